// ===== hw/rtl/bpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants for the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // fixed widths of the item fields
  localparam int unsigned TW     = 11;  // param_t
  localparam int unsigned PW     = 4;   // precision_bits
  localparam int unsigned ADDR_W = 5;   // APB byte address
  localparam int unsigned DATA_W = 32;  // APB data

  // curve type carried in the mode field
  localparam logic MODE_CUBIC = 1'b1;

  // register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } reg_idx_e;

endpackage

// ===== hw/rtl/bpe_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_item_if
// Valid/ready channel carrying one curve parameter sample.
// ----------------------------------------------------------------------------
interface bpe_item_if import bpe_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [TW-1:0] param_t;
  logic [PW-1:0] precision_bits;
  logic          mode;

  modport source (output valid, param_t, precision_bits, mode, input ready);
  modport sink   (input valid, param_t, precision_bits, mode, output ready);
endinterface

// ===== hw/rtl/bpe_point_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_point_if
// Valid/ready channel carrying one evaluated curve point.
// ----------------------------------------------------------------------------
interface bpe_point_if #(
  parameter int unsigned COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

// ===== hw/rtl/bezier_point_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_evaluator
// Fixed-point quadratic / cubic Bezier point evaluation, six-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   dir  kind        payload
//  in_i      in   valid/rdy   param_t[10:0], precision_bits[3:0], mode
//  out_o     out  valid/rdy   point_x, point_y (COORD_WIDTH, signed)
//  apb       in   APB write   eight control point coordinates, 4-byte stride
//
//  One beat per cycle in steady state while out_o is not stalled; a beat
//  passes through six register stages: the accepting edge loads stage 1,
//  and stages 2 to 5 in turn carry it into the output reg.
//  The whole pipeline moves on one advance enable: it advances when the
//  output register is empty or its beat is taken, so a stall freezes every
//  stage in place and nothing is dropped or repeated.
//  Reset clears all stage valid bits and the coordinate registers to zero.
//  Stages: t/c prep -> t*c, t*t, c*c -> Bernstein weights -> weight x coord
//  -> four-term sum -> arithmetic shift by 2p or 3p into the output reg.
// ----------------------------------------------------------------------------
module bezier_point_evaluator import bpe_pkg::*; #(
  parameter int unsigned COORD_WIDTH   = 24,
  parameter int unsigned MAX_PRECISION = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bpe_item_if.sink            in_i,
  bpe_point_if.source         out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // t and c hold 0..2^MAX_PRECISION
  localparam int unsigned WW    = MAX_PRECISION + 1;
  localparam int unsigned SQW   = 2 * WW;
  localparam int unsigned CUBW  = 3 * WW;
  // a weight is at most 2^(3p)
  localparam int unsigned WGTW  = 3 * MAX_PRECISION + 1;
  localparam int unsigned MULW  = WGTW + 1 + COORD_WIDTH;
  localparam int unsigned SUMW  = MULW + 2;
  localparam int unsigned SHW   = $clog2(3 * MAX_PRECISION + 1);
  localparam int unsigned NREG  = 8;

  typedef struct packed {
    logic           valid;
    logic [SHW-1:0] sh;
  } ctl_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] coord_q [NREG];
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREG; i++) begin
        coord_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      coord_q[paddr[4:2]] <= pwdata[COORD_WIDTH-1:0];
    end
  end

  // read data sign-extended to the bus width
  assign prdata = DATA_W'(coord_q[paddr[4:2]]);

  // --------------------------------------------------------------------------
  // Pipeline advance: everything moves together unless the output is stuck
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;

  assign adv      = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: saturate p and t, form c = 2^p - t, pick the final shift
  // --------------------------------------------------------------------------
  logic [PW-1:0]  p_sat;
  logic [WW-1:0]  n_val;
  logic [TW-1:0]  t_sat;
  logic [SHW-1:0] sh_d;

  ctl_t          s1_q;
  logic          s1_cubic_q;
  logic [WW-1:0] s1_t_q, s1_c_q;

  always_comb begin
    p_sat = (in_i.precision_bits > PW'(MAX_PRECISION)) ? PW'(MAX_PRECISION)
                                                       : in_i.precision_bits;
    n_val = WW'(1) << p_sat;
    t_sat = (in_i.param_t > TW'(n_val)) ? TW'(n_val) : in_i.param_t;
    sh_d  = (in_i.mode == MODE_CUBIC) ? SHW'(3 * p_sat) : SHW'(2 * p_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv) begin
      s1_q.valid <= in_i.valid;
      s1_q.sh    <= sh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cubic_q <= (in_i.mode == MODE_CUBIC);
      s1_t_q     <= WW'(t_sat);
      s1_c_q     <= n_val - WW'(t_sat);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: square terms
  // --------------------------------------------------------------------------
  ctl_t           s2_q;
  logic           s2_cubic_q;
  logic [WW-1:0]  s2_t_q, s2_c_q;
  logic [SQW-1:0] s2_tc_q, s2_tt_q, s2_cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (adv) begin
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_cubic_q <= s1_cubic_q;
      s2_t_q     <= s1_t_q;
      s2_c_q     <= s1_c_q;
      s2_tc_q    <= SQW'(s1_t_q) * SQW'(s1_c_q);
      s2_tt_q    <= SQW'(s1_t_q) * SQW'(s1_t_q);
      s2_cc_q    <= SQW'(s1_c_q) * SQW'(s1_c_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: Bernstein weights
  // --------------------------------------------------------------------------
  logic [CUBW-1:0] ccc, tcc, ttc, ttt;
  logic [CUBW+1:0] tcc3, ttc3;
  logic [WGTW-1:0] wgt_d [4];

  ctl_t            s3_q;
  logic [WGTW-1:0] s3_w_q [4];

  always_comb begin
    ccc  = CUBW'(s2_cc_q) * CUBW'(s2_c_q);
    tcc  = CUBW'(s2_tc_q) * CUBW'(s2_c_q);
    ttc  = CUBW'(s2_tt_q) * CUBW'(s2_c_q);
    ttt  = CUBW'(s2_tt_q) * CUBW'(s2_t_q);
    tcc3 = (CUBW+2)'({tcc, 1'b0}) + (CUBW+2)'(tcc);
    ttc3 = (CUBW+2)'({ttc, 1'b0}) + (CUBW+2)'(ttc);
    if (s2_cubic_q) begin
      wgt_d[0] = WGTW'(ccc);
      wgt_d[1] = WGTW'(tcc3);
      wgt_d[2] = WGTW'(ttc3);
      wgt_d[3] = WGTW'(ttt);
    end else begin
      wgt_d[0] = WGTW'(s2_cc_q);
      wgt_d[1] = WGTW'({s2_tc_q, 1'b0});
      wgt_d[2] = WGTW'(s2_tt_q);
      wgt_d[3] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (adv) begin
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s3_w_q[k] <= wgt_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: weight times coordinate, eight multipliers
  // --------------------------------------------------------------------------
  ctl_t                   s4_q;
  logic signed [MULW-1:0] s4_px_q [4];
  logic signed [MULW-1:0] s4_py_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (adv) begin
      s4_q <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s4_px_q[k] <= MULW'($signed({1'b0, s3_w_q[k]})) * MULW'(coord_q[2*k]);
        s4_py_q[k] <= MULW'($signed({1'b0, s3_w_q[k]})) * MULW'(coord_q[2*k+1]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: four-term sums
  // --------------------------------------------------------------------------
  ctl_t                   s5_q;
  logic signed [SUMW-1:0] s5_sx_q, s5_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '0;
    end else if (adv) begin
      s5_q <= s4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_sx_q    <= SUMW'(s4_px_q[0]) + SUMW'(s4_px_q[1])
                  + SUMW'(s4_px_q[2]) + SUMW'(s4_px_q[3]);
      s5_sy_q    <= SUMW'(s4_py_q[0]) + SUMW'(s4_py_q[1])
                  + SUMW'(s4_py_q[2]) + SUMW'(s4_py_q[3]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: floor shift by 2p / 3p into the output register
  // --------------------------------------------------------------------------
  logic signed [SUMW-1:0]        shx, shy;
  logic signed [COORD_WIDTH-1:0] point_x_q, point_y_q;

  assign shx = s5_sx_q >>> s5_q.sh;
  assign shy = s5_sy_q >>> s5_q.sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s5_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      point_x_q <= shx[COORD_WIDTH-1:0];
      point_y_q <= shy[COORD_WIDTH-1:0];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.point_x = point_x_q;
  assign out_o.point_y = point_y_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  logic [WW:0]     tc_sum;
  logic [WGTW+1:0] wgt_sum;

  assign tc_sum  = (WW+1)'(s1_t_q) + (WW+1)'(s1_c_q);
  assign wgt_sum = (WGTW+2)'(s3_w_q[0]) + (WGTW+2)'(s3_w_q[1])
                 + (WGTW+2)'(s3_w_q[2]) + (WGTW+2)'(s3_w_q[3]);

  // t + c is always 2^p
  a_tc_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.valid |-> $onehot(tc_sum))
    else $error("t + c is not a power of two");

  // Bernstein weights partition 2^(2p) or 2^(3p) exactly
  a_wgt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_q.valid |-> (wgt_sum == ((WGTW+2)'(1) << s3_q.sh)))
    else $error("weight sum does not match the shift");

  // shift never exceeds three times the largest precision
  a_sh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_q.valid |-> (32'(s5_q.sh) <= 3 * MAX_PRECISION))
    else $error("shift out of range");

  // a stall freezes the pipeline
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s5_q.valid) && $stable(s5_sx_q) && $stable(s1_q.valid))
    else $error("pipeline moved during a stall");
`endif

endmodule
